FILE: design/dgc_pkg.sv
// Shared types, register codes and constants of the dynamics gain computer.
package dgc_pkg;

  localparam int unsigned GAIN_TABLE_BITS_DEF = 10;

  // log2(10)/20 octaves per dB, scaled for a dB Q8 input and a Q32 result
  localparam logic [21:0] OCT_PER_DB_Q32 = 22'd2786635;

  typedef enum logic [2:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_RATIO     = 3'd1,
    CFG_KNEE      = 3'd2,
    CFG_MODE      = 3'd3,
    CFG_OUT_GAIN  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_COMP   = 2'd0,
    MODE_LIMIT  = 2'd1,
    MODE_EXPAND = 2'd2,
    MODE_GATE   = 2'd3
  } mode_e;

  typedef struct packed {
    logic signed [15:0] level_db;
    logic signed [15:0] sample;
  } in_t;

  typedef struct packed {
    logic        [15:0] gain;
    logic signed [15:0] out_sample;
  } out_t;

  // Bitwise integer square root, used only to build the octave table.
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

endpackage

FILE: design/dgc_div.sv
// Pipelined unsigned restoring divider with a sideband carried alongside.
module dgc_div #(
  parameter int unsigned NW  = 25,
  parameter int unsigned DW  = 13,
  parameter int unsigned SW  = 32,
  parameter int unsigned SPS = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [NW-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned NS = (NW + SPS - 1) / SPS;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [NW-1:0] qd;
    logic [DW-1:0] dv;
    logic [SW-1:0] sb;
  } div_st_t;

  div_st_t        st_in [NS];
  div_st_t        st_d  [NS];
  div_st_t        st_q  [NS];
  logic [NS-1:0]  v_q;

  assign st_in[0] = '{rem: '0, qd: dividend_i, dv: divisor_i, sb: side_i};

  for (genvar s = 0; s < NS; s++) begin : g_stage
    if (s > 0) begin : g_link
      assign st_in[s] = st_q[s-1];
    end

    always_comb begin
      div_st_t     w;
      logic [DW:0] t;
      w = st_in[s];
      t = '0;
      for (int k = 0; k < SPS; k++) begin
        if (s * SPS + k < NW) begin
          t = {w.rem, w.qd[NW-1]};
          if (t >= {1'b0, w.dv}) begin
            t    = t - {1'b0, w.dv};
            w.qd = {w.qd[NW-2:0], 1'b1};
          end else begin
            w.qd = {w.qd[NW-2:0], 1'b0};
          end
          w.rem = t[DW-1:0];
        end
      end
      st_d[s] = w;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) st_q[s] <= st_d[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= NS'({v_q, valid_i});
    end
  end

  assign valid_o = v_q[NS-1];
  assign quot_o  = st_q[NS-1].qd;
  assign side_o  = st_q[NS-1].sb;

endmodule

FILE: design/dgc_rom.sv
// Dual-read octave table 2^(-i/2^B) in Q30 with registered read data.
module dgc_rom #(
  parameter int unsigned GAIN_TABLE_BITS = dgc_pkg::GAIN_TABLE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [GAIN_TABLE_BITS-1:0] addr_a_i,
  input  logic [GAIN_TABLE_BITS-1:0] addr_b_i,
  output logic [30:0]                data_a_o,
  output logic [30:0]                data_b_o
);

  localparam int unsigned TblSize = 2 ** GAIN_TABLE_BITS;

  typedef logic [30:0] rom_t [TblSize];

  function automatic rom_t build_rom();
    logic [63:0] roots [GAIN_TABLE_BITS];
    rom_t        r;
    int unsigned low;
    logic [63:0] p;
    roots[GAIN_TABLE_BITS-1] = dgc_pkg::isqrt64(64'd1 << 59);
    for (int j = GAIN_TABLE_BITS - 1; j > 0; j--) begin
      roots[j-1] = dgc_pkg::isqrt64(roots[j] << 30);
    end
    r[0] = 31'h4000_0000;
    for (int i = 1; i < TblSize; i++) begin
      low = 0;
      while (((i >> low) & 1) == 0) low++;
      p = {33'd0, r[GAIN_TABLE_BITS'(i & (i - 1))]} * roots[low] + (64'd1 << 29);
      r[i] = p[60:30];
    end
    return r;
  endfunction

  localparam rom_t Rom = build_rom();

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_o <= Rom[addr_a_i];
      data_b_o <= Rom[addr_b_i];
    end
  end

endmodule

FILE: design/dgc_skid.sv
// Output register with one skid entry; freezes the pipeline only when both are full.
module dgc_skid (
  input  logic          clk_i,
  input  logic          rst_ni,
  output logic          en_o,
  input  logic          valid_i,
  input  dgc_pkg::out_t data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dgc_pkg::out_t out_data_o
);

  logic          out_v_q, out_v_d;
  logic          sk_v_q, sk_v_d;
  dgc_pkg::out_t out_d_q, out_d_d;
  dgc_pkg::out_t sk_d_q, sk_d_d;
  logic          out_free;
  logic          push;

  assign en_o     = !sk_v_q;
  assign out_free = !out_v_q || !out_stall_i;
  assign push     = valid_i && en_o;

  always_comb begin
    out_v_d = out_v_q;
    out_d_d = out_d_q;
    sk_v_d  = sk_v_q;
    sk_d_d  = sk_d_q;
    if (sk_v_q) begin
      if (out_free) begin
        out_d_d = sk_d_q;
        sk_v_d  = 1'b0;
      end
    end else if (push) begin
      if (out_free) begin
        out_v_d = 1'b1;
        out_d_d = data_i;
      end else begin
        // park the beat while the output waits
        sk_v_d = 1'b1;
        sk_d_d = data_i;
      end
    end else if (out_free) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      sk_v_q  <= sk_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_d_q <= out_d_d;
    sk_d_q  <= sk_d_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_d_q;

endmodule

FILE: design/dynamics_gain_computer_core.sv
// Static gain computer for compressor, limiter, expander and gate, with output scaling.
//
// One item is taken every cycle while in_stall_o is low. Its result passes through the
// two pipelined dividers (the 2^24/ratio reciprocal in 7 stages and the soft-knee slope
// interpolation in 10 stages, 4 quotient bits per stage), two stages of knee geometry
// ahead of the second divider, eight arithmetic stages for the gain in dB, the octave
// table lookup and the two output multiplies, and the output register. A stalled output
// holds one result in the output register and one more in a skid entry; the input stalls
// only when both are occupied, and the whole pipeline then holds. The user must write
// registers through the configuration port only while no item is in flight; the block
// itself does not enforce this. cfg_ready_o is always high.
module dynamics_gain_computer_core #(
  parameter int unsigned GAIN_TABLE_BITS = dgc_pkg::GAIN_TABLE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dgc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dgc_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i
);

  localparam int unsigned B = GAIN_TABLE_BITS;
  // at or below this gain in dB Q24 the rounded attenuation reaches 100 dB
  localparam logic signed [48:0] ZeroLim = -49'sd1677688832;

  // ---------------- configuration registers
  logic signed [14:0] threshold_q;
  logic        [12:0] ratio_q;
  logic        [12:0] knee_q;
  dgc_pkg::mode_e     mode_q;
  logic        [12:0] og_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
      ratio_q     <= 13'd256;
      knee_q      <= '0;
      mode_q      <= dgc_pkg::MODE_COMP;
      og_q        <= '0;
    end else if (cfg_valid_i) begin
      unique case (dgc_pkg::cfg_idx_e'(cfg_index_i))
        dgc_pkg::CFG_THRESHOLD: threshold_q <= cfg_data_i[14:0];
        dgc_pkg::CFG_RATIO:     ratio_q     <= cfg_data_i[12:0];
        dgc_pkg::CFG_KNEE:      knee_q      <= cfg_data_i[12:0];
        dgc_pkg::CFG_MODE:      mode_q      <= dgc_pkg::mode_e'(cfg_data_i[1:0]);
        dgc_pkg::CFG_OUT_GAIN:  og_q        <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign in_stall_o = !en;

  // ---------------- reciprocal 2^24 / ratio
  logic [12:0] ratio_eff;
  logic        v1;
  logic [24:0] q1;
  logic [31:0] sb1;

  assign ratio_eff = (ratio_q < 13'd256) ? 13'd256 : ratio_q;

  dgc_div #(.NW(25), .DW(13), .SW(32), .SPS(4)) u_div_inv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .dividend_i (25'h100_0000),
    .divisor_i  (ratio_eff),
    .side_i     (in_data_i),
    .valid_o    (v1),
    .quot_o     (q1),
    .side_o     (sb1)
  );

  // ---------------- stage A: slope and knee geometry
  typedef struct packed {
    logic signed [17:0] slope;
    logic               interp;
    logic signed [18:0] diff;
    logic        [14:0] den;
    logic signed [16:0] tl;
    logic signed [15:0] smp;
  } sa_t;

  sa_t  sa_d, sa_q;
  logic va_q;

  always_comb begin
    logic signed [17:0] inv;
    logic signed [15:0] lvl;
    logic signed [17:0] t2;
    logic signed [17:0] k;
    logic signed [17:0] x0;
    logic signed [17:0] x1;
    logic signed [17:0] x1c;
    logic signed [17:0] l2;
    logic               expand;
    inv    = $signed({1'b0, q1[16:0]});
    lvl    = $signed(sb1[31:16]);
    t2     = $signed({threshold_q[14], threshold_q[14], threshold_q, 1'b0});
    k      = $signed({5'd0, knee_q});
    x0     = t2 - k;
    x1     = t2 + k;
    x1c    = (x1 > 18'sd0) ? 18'sd0 : x1;
    l2     = $signed({lvl[15], lvl, 1'b0});
    expand = (mode_q == dgc_pkg::MODE_EXPAND) || (mode_q == dgc_pkg::MODE_GATE);
    unique case (mode_q)
      dgc_pkg::MODE_COMP:   sa_d.slope = 18'sd65536 - inv;
      dgc_pkg::MODE_LIMIT:  sa_d.slope = 18'sd65536;
      dgc_pkg::MODE_EXPAND: sa_d.slope = inv - 18'sd65536;
      default:              sa_d.slope = -18'sd65536;
    endcase
    sa_d.interp = (knee_q != 13'd0) && (l2 > x0) && (l2 < x1) && (x1c > x0);
    sa_d.diff   = expand ? (19'(x1c) - 19'(l2)) : (19'(l2) - 19'(x0));
    sa_d.den    = 15'(x1c - x0);
    sa_d.tl     = 17'(threshold_q) - 17'(lvl);
    sa_d.smp    = $signed(sb1[15:0]);
  end

  // ---------------- stage B: interpolation numerator
  typedef struct packed {
    logic        [36:0] mag;
    logic               neg;
    logic               interp;
    logic signed [17:0] slope;
    logic        [14:0] den;
    logic signed [16:0] tl;
    logic signed [15:0] smp;
  } sb_t;

  sb_t  sb_d, sb_q;
  logic vb_q;

  always_comb begin
    logic signed [36:0] num;
    num         = 37'(sa_q.slope) * 37'(sa_q.diff);
    sb_d.neg    = num[36];
    sb_d.mag    = num[36] ? (37'd0 - num) : num;
    sb_d.interp = sa_q.interp;
    sb_d.slope  = sa_q.slope;
    sb_d.den    = sa_q.den;
    sb_d.tl     = sa_q.tl;
    sb_d.smp    = sa_q.smp;
  end

  // ---------------- slope interpolation divider
  logic        v2;
  logic [36:0] q2;
  logic [52:0] sb2;

  dgc_div #(.NW(37), .DW(15), .SW(53), .SPS(4)) u_div_knee (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (vb_q),
    .dividend_i (sb_q.mag),
    .divisor_i  (sb_q.den),
    .side_i     ({sb_q.neg, sb_q.interp, sb_q.slope, sb_q.tl, sb_q.smp}),
    .valid_o    (v2),
    .quot_o     (q2),
    .side_o     (sb2)
  );

  // ---------------- stage C: final slope
  logic signed [31:0] sf_q;
  logic signed [16:0] tl_c_q;
  logic signed [15:0] smp_c_q;
  logic               vc_q;
  logic signed [31:0] sf_d;

  always_comb begin
    logic [31:0] qm;
    qm   = {1'b0, q2[30:0]};
    // the interpolated slope stays below 2^30 in magnitude
    sf_d = sb2[51] ? $signed(sb2[52] ? (32'd0 - qm) : qm) : 32'($signed(sb2[50:33]));
  end

  // ---------------- stage D: gain in dB, Q24
  logic signed [48:0] yg_q;
  logic signed [15:0] smp_d_q;
  logic               vd_q;

  // ---------------- stage E: rounded attenuation, Q8
  logic        [14:0] aq_q;
  logic               nonneg_e_q, zero_e_q;
  logic signed [15:0] smp_e_q;
  logic               ve_q;
  logic signed [49:0] att_r;

  assign att_r = 50'sd32768 - 50'(yg_q);

  // ---------------- stage F: octave conversion
  logic        [36:0] e_q;
  logic        [34:0] e2_q;
  logic               nonneg_f_q, zero_f_q;
  logic signed [15:0] smp_f_q;
  logic               vf_q;

  // ---------------- stage G: table lookup
  logic [B-1:0] idx2;
  logic [B-1:0] addr_b;
  logic [3:0]   sh2_d;
  logic [30:0]  rom_a, rom_b;
  logic [4:0]   n_g_q;
  logic [3:0]   sh2_g_q;
  logic         nonneg_g_q, zero_g_q;
  logic signed [15:0] smp_g_q;
  logic         vg_q;

  assign idx2   = e2_q[31 -: B];
  assign addr_b = '0 - idx2;
  assign sh2_d  = (idx2 == '0) ? {1'b0, e2_q[34:32]} : ({1'b0, e2_q[34:32]} + 4'd1);

  dgc_rom #(.GAIN_TABLE_BITS(B)) u_rom (
    .clk_i    (clk_i),
    .en_i     (en),
    .addr_a_i (e_q[31 -: B]),
    .addr_b_i (addr_b),
    .data_a_o (rom_a),
    .data_b_o (rom_b)
  );

  // ---------------- stage H: linear gain and make-up factor
  logic [15:0] gain_d;
  logic [22:0] mk_d;
  logic [15:0] gain_h_q;
  logic [22:0] mk_h_q;
  logic signed [15:0] smp_h_q;
  logic        vh_q;

  always_comb begin
    logic [30:0] g;
    logic [31:0] gr;
    logic [36:0] lin;
    logic [37:0] lr;
    g   = rom_a >> n_g_q;
    gr  = {1'b0, g} + 32'd16384;
    lin = {6'd0, rom_b} << sh2_g_q;
    lr  = {1'b0, lin} + 38'd8192;
    priority if (nonneg_g_q) gain_d = 16'd32768;
    else if (zero_g_q)       gain_d = 16'd0;
    else                     gain_d = gr[30:15];
    mk_d = lr[36:14];
  end

  // ---------------- stage I and J: scale the sample
  logic [32:0] p1_d;
  logic [32:0] p1_q;
  logic        neg_i_q;
  logic [15:0] gain_i_q;
  logic [22:0] mk_i_q;
  logic        vi_q;
  logic [55:0] prod_q;
  logic        neg_j_q;
  logic [15:0] gain_j_q;
  logic        vj_q;

  always_comb begin
    logic [16:0] mag;
    mag  = smp_h_q[15] ? (17'd0 - {smp_h_q[15], smp_h_q}) : {1'b0, smp_h_q};
    p1_d = 33'(mag) * 33'(gain_h_q);
  end

  // round, saturate
  dgc_pkg::out_t res;

  always_comb begin
    logic [56:0] r;
    logic [25:0] m;
    r = {1'b0, prod_q} + 57'(64'd1 << 30);
    m = r[56:31];
    res.gain = gain_j_q;
    if (neg_j_q) begin
      res.out_sample = (m > 26'd32768) ? 16'sh8000 : $signed(16'd0 - m[15:0]);
    end else begin
      res.out_sample = (m > 26'd32767) ? 16'sh7fff : $signed(m[15:0]);
    end
  end

  // ---------------- pipeline registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
      vh_q <= 1'b0;
      vi_q <= 1'b0;
      vj_q <= 1'b0;
    end else if (en) begin
      va_q <= v1;
      vb_q <= va_q;
      vc_q <= v2;
      vd_q <= vc_q;
      ve_q <= vd_q;
      vf_q <= ve_q;
      vg_q <= vf_q;
      vh_q <= vg_q;
      vi_q <= vh_q;
      vj_q <= vi_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q       <= sa_d;
      sb_q       <= sb_d;
      sf_q       <= sf_d;
      tl_c_q     <= $signed(sb2[32:16]);
      smp_c_q    <= $signed(sb2[15:0]);
      yg_q       <= 49'(sf_q) * 49'(tl_c_q);
      smp_d_q    <= smp_c_q;
      aq_q       <= att_r[30:16];
      nonneg_e_q <= !yg_q[48];
      zero_e_q   <= (yg_q <= ZeroLim);
      smp_e_q    <= smp_d_q;
      e_q        <= 37'(aq_q) * 37'(dgc_pkg::OCT_PER_DB_Q32);
      e2_q       <= 35'(og_q) * 35'(dgc_pkg::OCT_PER_DB_Q32);
      nonneg_f_q <= nonneg_e_q;
      zero_f_q   <= zero_e_q;
      smp_f_q    <= smp_e_q;
      n_g_q      <= e_q[36:32];
      sh2_g_q    <= sh2_d;
      nonneg_g_q <= nonneg_f_q;
      zero_g_q   <= zero_f_q;
      smp_g_q    <= smp_f_q;
      gain_h_q   <= gain_d;
      mk_h_q     <= mk_d;
      smp_h_q    <= smp_g_q;
      p1_q       <= p1_d;
      neg_i_q    <= smp_h_q[15];
      gain_i_q   <= gain_h_q;
      mk_i_q     <= mk_h_q;
      prod_q     <= 56'(p1_q) * 56'(mk_i_q);
      neg_j_q    <= neg_i_q;
      gain_j_q   <= gain_i_q;
    end
  end

  dgc_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_o        (en),
    .valid_i     (vj_q),
    .data_i      (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: design/dgc_checker.sv
// Port-level checks of the gain computer, bound to the top level.
module dgc_port_checks (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input dgc_pkg::out_t out_data_o
);

  // a held result beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("held result beat changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.gain <= 16'd32768)
    else $error("gain above unity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.gain == 16'd0 |-> out_data_o.out_sample == 16'sd0)
    else $error("nonzero sample at zero gain");

  // input holds only while a result sits in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule

bind dynamics_gain_computer_core dgc_port_checks u_dgc_port_checks (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

FILE: tb/dgc_checker.sv
// Checker for the dynamics gain computer: predicts each result and compares it.
module dgc_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  dgc_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  dgc_pkg::out_t out_data_i,
  input  logic          cfg_valid_i,
  input  logic          cfg_ready_i,
  input  logic [2:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i,
  output int            errors_o,
  output int            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TBL_BITS = 10;
  localparam int unsigned TBL_SIZE = 1 << TBL_BITS;
  localparam longint OCT_Q32 = 2786635;

  longint unsigned octave_tbl[TBL_SIZE];

  logic signed [14:0] thr_q8;
  logic [12:0]        ratio_q8;
  logic [12:0]        knee_q8;
  dgc_pkg::mode_e     dyn_mode;
  logic [12:0]        makeup_db_q8;

  dgc_pkg::out_t expected_results[$];
  int            mismatches;

  assign errors_o  = mismatches;
  assign pending_o = expected_results.size();

  function automatic longint unsigned int_root(input longint unsigned v_in);
    longint unsigned v, r, b;
    v = v_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(-i/TBL_SIZE) in Q30, built from repeated square roots of one half
  initial begin
    longint unsigned roots[TBL_BITS];
    int low;
    roots[TBL_BITS-1] = int_root(64'd1 << 59);
    for (int j = TBL_BITS - 1; j > 0; j--) roots[j-1] = int_root(roots[j] << 30);
    octave_tbl[0] = 64'd1 << 30;
    for (int i = 1; i < TBL_SIZE; i++) begin
      low = 0;
      while (((i >> low) & 1) == 0) low++;
      octave_tbl[i] = (octave_tbl[i & (i - 1)] * roots[low] + (64'd1 << 29)) >> 30;
    end
  end

  function automatic longint atten_gain_q15(input longint a_q8);
    longint e, n, idx;
    if (a_q8 >= 25600) return 0;
    e   = a_q8 * OCT_Q32;
    n   = e >> 32;
    idx = (e >> (32 - TBL_BITS)) & (TBL_SIZE - 1);
    return ((octave_tbl[idx] >> n) + (64'd1 << 14)) >> 15;
  endfunction

  function automatic longint makeup_q16(input longint d_q8);
    longint e, n, idx, lin;
    e   = d_q8 * OCT_Q32;
    n   = e >> 32;
    idx = (e >> (32 - TBL_BITS)) & (TBL_SIZE - 1);
    if (idx == 0) lin = octave_tbl[0] << n;
    else          lin = octave_tbl[TBL_SIZE - idx] << (n + 1);
    return (lin + (64'd1 << 13)) >> 14;
  endfunction

  function automatic dgc_pkg::out_t scale_sample(input dgc_pkg::in_t d);
    longint        lvl, smp, t, r, inv, slope, yg, k, x0, x1, l2, gain, mag;
    dgc_pkg::out_t o;
    lvl = longint'(d.level_db);
    smp = longint'(d.sample);
    t   = longint'(thr_q8);
    r   = (ratio_q8 < 256) ? 256 : longint'(ratio_q8);
    inv = 16777216 / r;
    case (dyn_mode)
      dgc_pkg::MODE_COMP:   slope = 65536 - inv;
      dgc_pkg::MODE_LIMIT:  slope = 65536;
      dgc_pkg::MODE_EXPAND: slope = inv - 65536;
      default:              slope = -65536;
    endcase
    if (knee_q8 != 0) begin
      k  = longint'(knee_q8);
      x0 = 2 * t - k;
      x1 = 2 * t + k;
      l2 = 2 * lvl;
      if (l2 > x0 && l2 < x1) begin
        if (x1 > 0) x1 = 0;
        // degenerate knee falls through with the plain slope
        if (x1 > x0) begin
          if (dyn_mode == dgc_pkg::MODE_COMP || dyn_mode == dgc_pkg::MODE_LIMIT)
            slope = slope * (l2 - x0) / (x1 - x0);
          else
            slope = slope * (x1 - l2) / (x1 - x0);
        end
      end
    end
    yg = slope * (t - lvl);
    if (yg >= 0) gain = 32768;
    else if (-yg >= (longint'(25600) << 16)) gain = 0;
    else gain = atten_gain_q15((-yg + 32768) >> 16);
    mag = (smp < 0) ? -smp : smp;
    mag = (mag * gain * makeup_q16(longint'(makeup_db_q8)) + (64'd1 << 30)) >> 31;
    if (smp < 0) begin
      if (mag > 32768) mag = 32768;
      o.out_sample = 16'(-mag);
    end else begin
      if (mag > 32767) mag = 32767;
      o.out_sample = 16'(mag);
    end
    o.gain = 16'(gain);
    return o;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  initial mismatches = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    dgc_pkg::out_t want;
    if (!rst_ni) begin
      thr_q8       <= '0;
      ratio_q8     <= 13'd256;
      knee_q8      <= '0;
      dyn_mode     <= dgc_pkg::MODE_COMP;
      makeup_db_q8 <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (dgc_pkg::cfg_idx_e'(cfg_index_i))
          dgc_pkg::CFG_THRESHOLD: thr_q8       <= cfg_data_i[14:0];
          dgc_pkg::CFG_RATIO:     ratio_q8     <= cfg_data_i[12:0];
          dgc_pkg::CFG_KNEE:      knee_q8      <= cfg_data_i[12:0];
          dgc_pkg::CFG_MODE:      dyn_mode     <= dgc_pkg::mode_e'(cfg_data_i[1:0]);
          dgc_pkg::CFG_OUT_GAIN:  makeup_db_q8 <= cfg_data_i[12:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) expected_results.push_back(scale_sample(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report("unexpected beat", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.gain !== want.gain)
            report("gain", out_data_i.gain, want.gain);
          if (out_data_i.out_sample !== want.out_sample)
            report("out_sample", out_data_i.out_sample, want.out_sample);
        end
      end
    end
  end

endmodule

FILE: tb/testbench.sv
// Top of the dynamics gain computer testbench: stimulus, stall patterns and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 40;
  localparam int STUCK_LIMIT  = 5000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  dgc_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  dgc_pkg::out_t out_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [2:0]    cfg_index = '0;
  logic [15:0]   cfg_data = '0;
  int            errors, pending;
  int            tx_pct = 0, rx_pct = 0;
  int            hold_req = 0;
  int            hold_left = 0;
  int            idle_cycles = 0;
  logic signed [15:0] cur_thr = '0;
  int            cur_knee = 0;

  always #10 clk = ~clk;

  dynamics_gain_computer_core i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  dgc_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  // receiver: random stalls, or a long hold when one is requested
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  <= 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STUCK_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // stop offering and wait until every expected result has come
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input int thr, input int ratio, input int knee,
                          input dgc_pkg::mode_e m, input int og);
    dgc_pkg::cfg_idx_e idx;
    int vals[5];
    vals = '{thr, ratio, knee, int'(m), og};
    for (int i = 0; i < 5; i++) begin
      idx = dgc_pkg::cfg_idx_e'(i);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= 16'(vals[i]);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cur_thr  = 16'(signed'(15'(thr)));
    cur_knee = knee;
  endtask

  task automatic send(input logic [15:0] lvl, input logic [15:0] smp);
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{level_db: lvl, sample: smp};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_level();
    int span;
    case ($urandom_range(9))
      0, 1:    return 16'($urandom);
      2:       return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      default: begin
        span = cur_knee / 2 + 768;
        return 16'(int'(cur_thr) + $urandom_range(2 * span) - span);
      end
    endcase
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int thr;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every mode around a soft knee, extremes of both fields
    for (int m = 0; m < 4; m++) begin
      set_regs(-5120, 1024, 1024, dgc_pkg::mode_e'(m), 0);
      send(16'h8000, 16'h7fff);
      send(16'h7fff, 16'h8000);
      send(16'(-5120 - 256), 16'd1000);
      send(16'(-5120 + 200), 16'hffff);
      send(16'(-5120), 16'd0);
      drain();
    end
    send(16'h8000, 16'h7fff);
    drain();
    // ratio below one, deep gate attenuation, degenerate knee, output overflow
    set_regs(0, 0, 0, dgc_pkg::MODE_GATE, 5120);
    send(16'h8000, 16'h7fff);
    send(16'(-100), 16'h8000);
    drain();
    set_regs(4000, 700, 1000, dgc_pkg::MODE_COMP, 8191);
    send(16'd3900, 16'h7fff);
    send(16'd4100, 16'h8000);
    send(16'd0, 16'd12345);
    drain();

    for (int p = 0; p < 9; p++) begin
      case (p / 3)
        0:       begin tx_pct = 11; rx_pct = 79; end
        1:       begin tx_pct = 79; rx_pct = 11; end
        default: begin tx_pct = 0;  rx_pct = 0;  end
      endcase
      case (p)
        0: set_regs(-15360, 5120, 5120, dgc_pkg::MODE_COMP, 0);
        1: set_regs(16383, 8191, 8191, dgc_pkg::MODE_GATE, 8191);
        2: set_regs(0, 256, 0, dgc_pkg::MODE_EXPAND, 5120);
        3: set_regs(-16384, 0, 1, dgc_pkg::MODE_LIMIT, 1);
        default: begin
          thr = ($urandom_range(3) == 0) ? $urandom_range(32767) - 16384
                                         : -int'($urandom_range(15360));
          set_regs(thr, $urandom_range(8191), $urandom_range(8191),
                   dgc_pkg::mode_e'($urandom_range(3)), $urandom_range(8191));
        end
      endcase
      for (int n = 0; n < 100; n++) begin
        if (p == 2 && n == 10) hold_req <= 300;
        if (p == 4 && n == 50) drain();
        send(pick_level(), pick_sample());
      end
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/dgc_pkg.sv
design/dgc_div.sv
design/dgc_rom.sv
design/dgc_skid.sv
design/dynamics_gain_computer_core.sv
design/dgc_checker.sv
tb/dgc_checker.sv
tb/testbench.sv
